// ===== rtl/fcr_pkg.sv =====
`default_nettype none

package fcr_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 32;
  localparam int unsigned QUEUE_SLOTS_DEF = 8;
  localparam int unsigned CMD_DEPTH       = 2;

  // Field widths of the request passed from the parser to the executor, sized for the
  // largest payload limit the block supports (64 bytes).
  localparam int unsigned LEN_W_MAX = 7;
  localparam int unsigned IDX_W_MAX = 6;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] RST_CODE_UP_ON    = 8'd0;
  localparam logic [7:0] RST_CODE_UP_OFF   = 8'd1;
  localparam logic [7:0] RST_CODE_DATA     = 8'd2;
  localparam logic [7:0] RST_CODE_ST_ON    = 8'd3;
  localparam logic [7:0] RST_CODE_ST_OFF   = 8'd4;
  localparam logic [7:0] RST_COMMAND_COUNT = 8'd5;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_UP_ON     = 3'd0,
    REG_UP_OFF    = 3'd1,
    REG_DATA      = 3'd2,
    REG_ST_ON     = 3'd3,
    REG_ST_OFF    = 3'd4,
    REG_CMD_COUNT = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_UP_ON  = 3'd1,
    ACT_UP_OFF = 3'd2,
    ACT_DATA   = 3'd3,
    ACT_ST_ON  = 3'd4,
    ACT_ST_OFF = 3'd5
  } act_e;

  typedef struct packed {
    logic [7:0] code_upstream_on;
    logic [7:0] code_upstream_off;
    logic [7:0] code_data;
    logic [7:0] code_store_on;
    logic [7:0] code_store_off;
    logic [7:0] command_count;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_out;
    logic        last;
    logic        frame_ok;
    logic        upstream_on;
    logic        store_on;
    logic [15:0] error_count;
    logic [15:0] drop_count;
    logic [3:0]  queued;
  } out_item_t;

  typedef struct packed {
    logic                 is_tick;
    logic                 wr_en;
    logic [IDX_W_MAX-1:0] wr_idx;
    logic [7:0]           data;
    logic                 done_ok;
    act_e                 act;
    logic [LEN_W_MAX-1:0] length;
    logic [15:0]          errors;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fcr_front.sv =====
`default_nettype none

module fcr_front #(
  parameter int unsigned PAYLOAD_MAX = fcr_pkg::PAYLOAD_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcr_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fcr_pkg::in_item_t in_data_i,
  input  logic             cmd_full_i,
  output logic             cmd_push_o,
  output fcr_pkg::cmd_t    cmd_o
);

  localparam int unsigned LW = $clog2(PAYLOAD_MAX + 1);
  localparam int unsigned IW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  typedef enum logic [3:0] {
    PH_CMD   = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]    exp_q, exp_d;
  logic [7:0]    xor_q, xor_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [15:0]   err_q, err_d;

  logic          accept;
  logic [7:0]    b;
  logic [LW-1:0] idx_inc;
  logic          done;
  logic          ok;
  logic          bump;
  logic          wr_en;
  fcr_pkg::act_e act;

  assign accept     = in_valid_i && !cmd_full_i;
  assign in_stall_o = cmd_full_i;
  assign cmd_push_o = accept;
  assign b          = in_data_i.data_in;
  assign idx_inc    = idx_q + 1'b1;

  // First matching code in register order decides the action.
  always_comb begin
    if (cmd_q == cfg_i.code_upstream_on) begin
      act = fcr_pkg::ACT_UP_ON;
    end else if (cmd_q == cfg_i.code_upstream_off) begin
      act = fcr_pkg::ACT_UP_OFF;
    end else if (cmd_q == cfg_i.code_data) begin
      act = fcr_pkg::ACT_DATA;
    end else if (cmd_q == cfg_i.code_store_on) begin
      act = fcr_pkg::ACT_ST_ON;
    end else if (cmd_q == cfg_i.code_store_off) begin
      act = fcr_pkg::ACT_ST_OFF;
    end else begin
      act = fcr_pkg::ACT_NONE;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    exp_d   = exp_q;
    xor_d   = xor_q;
    idx_d   = idx_q;
    err_d   = err_q;
    done    = 1'b0;
    ok      = 1'b0;
    bump    = 1'b0;
    wr_en   = 1'b0;
    if (accept && !in_data_i.op) begin
      unique case (phase_q)
        PH_CMD: begin
          if (b < cfg_i.command_count) begin
            cmd_d   = b;
            xor_d   = b;
            phase_d = PH_LEN;
          end else begin
            bump = 1'b1;
          end
        end
        PH_LEN: begin
          if (b <= 8'(PAYLOAD_MAX)) begin
            len_d   = b[LW-1:0];
            xor_d   = xor_q ^ b;
            phase_d = PH_CHECK;
          end else begin
            bump    = 1'b1;
            phase_d = PH_CMD;
          end
        end
        PH_CHECK: begin
          exp_d = b;
          idx_d = '0;
          if (len_q != '0) begin
            phase_d = PH_DATA;
          end else begin
            done = 1'b1;
          end
        end
        PH_DATA: begin
          wr_en = 1'b1;
          xor_d = xor_q ^ b;
          idx_d = idx_inc;
          if (idx_inc >= len_q) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_d = PH_CMD;
        end
      endcase
      if (done) begin
        phase_d = PH_CMD;
        idx_d   = '0;
        if (xor_d == exp_d) begin
          ok = 1'b1;
        end else begin
          bump = 1'b1;
        end
      end
      if (bump && (err_q != 16'hFFFF)) begin
        err_d = err_q + 16'd1;
      end
    end
  end

  always_comb begin
    cmd_o.is_tick = in_data_i.op;
    cmd_o.wr_en   = wr_en;
    cmd_o.wr_idx  = fcr_pkg::IDX_W_MAX'(idx_q[IW-1:0]);
    cmd_o.data    = b;
    cmd_o.done_ok = ok;
    cmd_o.act     = act;
    cmd_o.length  = fcr_pkg::LEN_W_MAX'(len_q);
    cmd_o.errors  = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      cmd_q   <= '0;
      len_q   <= '0;
      exp_q   <= '0;
      xor_q   <= '0;
      idx_q   <= '0;
      err_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      exp_q   <= exp_d;
      xor_q   <= xor_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcr_cmd_fifo.sv =====
`default_nettype none

module fcr_cmd_fifo #(
  parameter int unsigned DEPTH = fcr_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fcr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fcr_pkg::cmd_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fcr_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcr_back.sv =====
`default_nettype none

module fcr_back #(
  parameter int unsigned PAYLOAD_MAX = fcr_pkg::PAYLOAD_MAX_DEF,
  parameter int unsigned QUEUE_SLOTS = fcr_pkg::QUEUE_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  fcr_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcr_pkg::out_item_t out_data_o
);

  // One spare slot beyond the queue depth: the frame being received always has a free
  // slot to land in, even when every other slot holds a waiting packet.
  localparam int unsigned NSLOT     = QUEUE_SLOTS + 1;
  localparam int unsigned SW        = $clog2(NSLOT);
  localparam int unsigned FW        = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned LW        = $clog2(PAYLOAD_MAX + 1);
  localparam int unsigned IW        = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int unsigned MEM_DEPTH = NSLOT << IW;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_LEN   = 5'b00010,
    B_EMPTY = 5'b00100,
    B_DATA  = 5'b01000,
    B_EMIT  = 5'b10000
  } bstate_e;

  logic [7:0]    pay_mem [MEM_DEPTH];
  logic [LW-1:0] len_mem [NSLOT];

  bstate_e       state_q, state_d;
  logic          flag_up_q, flag_up_d;
  logic          flag_st_q, flag_st_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   drops_q, drops_d;
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [SW-1:0] rd_slot_q, rd_slot_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   err_q, err_d;
  logic [LW-1:0] len_rd_q;
  logic [7:0]    byte_q;
  logic          out_valid_q;
  fcr_pkg::out_item_t out_q, out_d;

  logic          out_free;
  logic          emit;
  logic          pay_we;
  logic          len_we;
  logic [1:0]    kind;
  logic [7:0]    dout;
  logic          last;
  logic          ok;
  logic [LW-1:0] cnt_inc;
  logic [FW+3:0] fill_ext;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(NSLOT - 1)) ? '0 : s + 1'b1;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_inc  = cnt_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    flag_up_d = flag_up_q;
    flag_st_d = flag_st_q;
    fill_d    = fill_q;
    drops_d   = drops_q;
    head_d    = head_q;
    tail_d    = tail_q;
    rd_slot_d = rd_slot_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    err_d     = err_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    pay_we    = 1'b0;
    len_we    = 1'b0;
    kind      = fcr_pkg::KIND_STATUS;
    dout      = 8'd0;
    last      = 1'b1;
    ok        = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          err_d     = cmd_i.errors;
          if (!cmd_i.is_tick) begin
            emit   = 1'b1;
            ok     = cmd_i.done_ok;
            pay_we = cmd_i.wr_en;
            if (cmd_i.done_ok) begin
              unique case (cmd_i.act)
                fcr_pkg::ACT_UP_ON:  flag_up_d = 1'b1;
                fcr_pkg::ACT_UP_OFF: flag_up_d = 1'b0;
                fcr_pkg::ACT_ST_ON:  flag_st_d = 1'b1;
                fcr_pkg::ACT_ST_OFF: flag_st_d = 1'b0;
                fcr_pkg::ACT_DATA: begin
                  if (fill_q < FW'(QUEUE_SLOTS)) begin
                    len_we = 1'b1;
                    tail_d = slot_inc(tail_q);
                    fill_d = fill_q + 1'b1;
                  end else if (drops_q != 16'hFFFF) begin
                    drops_d = drops_q + 16'd1;
                  end
                end
                default: ;
              endcase
            end
          end else if (!(flag_up_q || flag_st_q) || (fill_q == '0)) begin
            emit = 1'b1;
            kind = fcr_pkg::KIND_NONE;
          end else begin
            state_d = B_LEN;
          end
        end
      end
      B_LEN: begin
        rd_slot_d = head_q;
        len_d     = len_rd_q;
        cnt_d     = '0;
        head_d    = slot_inc(head_q);
        fill_d    = fill_q - 1'b1;
        state_d   = (len_rd_q == '0) ? B_EMPTY : B_DATA;
      end
      B_EMPTY: begin
        if (out_free) begin
          emit    = 1'b1;
          kind    = fcr_pkg::KIND_EMPTY;
          state_d = B_IDLE;
        end
      end
      B_DATA: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          kind    = fcr_pkg::KIND_DATA;
          dout    = byte_q;
          last    = (cnt_inc == len_q);
          cnt_d   = cnt_inc;
          state_d = last ? B_IDLE : B_DATA;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    fill_ext          = {4'b0, fill_d};
    out_d.kind        = kind;
    out_d.data_out    = dout;
    out_d.last        = last;
    out_d.frame_ok    = ok;
    out_d.upstream_on = flag_up_d;
    out_d.store_on    = flag_st_d;
    out_d.error_count = err_d;
    out_d.drop_count  = drops_d;
    out_d.queued      = fill_ext[3:0];
  end

  // Payload bytes of the frame in progress go straight into the tail slot; the slot only
  // joins the queue when the frame checks out.
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[{tail_q, cmd_i.wr_idx[IW-1:0]}] <= cmd_i.data;
    end
    byte_q <= pay_mem[{rd_slot_q, cnt_q[IW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[tail_q] <= cmd_i.length[LW-1:0];
    end
    len_rd_q <= len_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_slot_d;
    cnt_q     <= cnt_d;
    len_q     <= len_d;
    err_q     <= err_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      flag_up_q   <= 1'b0;
      flag_st_q   <= 1'b0;
      fill_q      <= '0;
      drops_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      flag_up_q <= flag_up_d;
      flag_st_q <= flag_st_d;
      fill_q    <= fill_d;
      drops_q   <= drops_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/framed_command_receiver_fifo.sv =====
// A received byte's status result passes through the command queue and the registered output
// stage when the output is free; the parser and executor are split by a two-entry queue.
// Throughput: one received byte per cycle while the output is free and no tick is served.
// A service tick pops the request, reads the packet length, then runs B_DATA and B_EMIT for
// each payload byte (B_EMPTY for an empty packet), as the memory reads are registered.
// Reset is asynchronous, active low; it clears control state and counters, no memory sweep.
`default_nettype none

module framed_command_receiver_fifo #(
  parameter int unsigned PAYLOAD_MAX = fcr_pkg::PAYLOAD_MAX_DEF,
  parameter int unsigned QUEUE_SLOTS = fcr_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fcr_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fcr_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcr_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcr_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  fcr_pkg::cfg_t cfg_q;
  fcr_pkg::reg_e reg_sel;
  logic          cfg_we;
  logic          cmd_push, cmd_full, cmd_pop, cmd_valid;
  fcr_pkg::cmd_t cmd_in, cmd_out;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = fcr_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_upstream_on  <= fcr_pkg::RST_CODE_UP_ON;
      cfg_q.code_upstream_off <= fcr_pkg::RST_CODE_UP_OFF;
      cfg_q.code_data         <= fcr_pkg::RST_CODE_DATA;
      cfg_q.code_store_on     <= fcr_pkg::RST_CODE_ST_ON;
      cfg_q.code_store_off    <= fcr_pkg::RST_CODE_ST_OFF;
      cfg_q.command_count     <= fcr_pkg::RST_COMMAND_COUNT;
    end else if (cfg_we) begin
      unique case (reg_sel)
        fcr_pkg::REG_UP_ON:     cfg_q.code_upstream_on  <= pwdata[7:0];
        fcr_pkg::REG_UP_OFF:    cfg_q.code_upstream_off <= pwdata[7:0];
        fcr_pkg::REG_DATA:      cfg_q.code_data         <= pwdata[7:0];
        fcr_pkg::REG_ST_ON:     cfg_q.code_store_on     <= pwdata[7:0];
        fcr_pkg::REG_ST_OFF:    cfg_q.code_store_off    <= pwdata[7:0];
        fcr_pkg::REG_CMD_COUNT: cfg_q.command_count     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fcr_pkg::REG_UP_ON:     prdata = {24'd0, cfg_q.code_upstream_on};
      fcr_pkg::REG_UP_OFF:    prdata = {24'd0, cfg_q.code_upstream_off};
      fcr_pkg::REG_DATA:      prdata = {24'd0, cfg_q.code_data};
      fcr_pkg::REG_ST_ON:     prdata = {24'd0, cfg_q.code_store_on};
      fcr_pkg::REG_ST_OFF:    prdata = {24'd0, cfg_q.code_store_off};
      fcr_pkg::REG_CMD_COUNT: prdata = {24'd0, cfg_q.command_count};
      default:                prdata = '0;
    endcase
  end

  fcr_front #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  fcr_cmd_fifo #(
    .DEPTH(fcr_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  fcr_back #(
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/fcr_checker.sv =====
`default_nettype none

module fcr_checker #(
  parameter int unsigned QUEUE_SLOTS = fcr_pkg::QUEUE_SLOTS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fcr_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only packet data results carry a byte, and every other result ends its request.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != fcr_pkg::KIND_DATA)
      |-> (out_data_o.data_out == 8'd0) && out_data_o.last)
    else $error("non-data result with payload or without last mark");

  a_ok_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_ok |-> out_data_o.kind == fcr_pkg::KIND_STATUS)
    else $error("frame_ok set on a service tick result");

  a_queued_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (QUEUE_SLOTS > 15) || (out_data_o.queued <= QUEUE_SLOTS))
    else $error("queue fill beyond its depth");

endmodule

bind framed_command_receiver_fifo fcr_checker #(
  .QUEUE_SLOTS(QUEUE_SLOTS)
) u_fcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
